>>> design/ethernet_ip_protocol_histogram_unit_defines.svh
// assertion macros for the ip protocol histogram rtl
// no dependencies
`ifndef ETHERNET_IP_PROTOCOL_HISTOGRAM_UNIT_DEFINES_SVH
`define ETHERNET_IP_PROTOCOL_HISTOGRAM_UNIT_DEFINES_SVH

// same-cycle implication
`define EHIST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define EHIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> design/ehist_pkg.sv
// types and constants for the ip protocol histogram
// no dependencies
`default_nettype none

package ehist_pkg;

  localparam int CounterDepth  = 256;
  localparam int IdxWidth      = $clog2(CounterDepth);
  localparam int CountWidth    = 32;
  localparam int OutCountWidth = 32;
  localparam int FifoDepth     = 4;
  localparam int PtrWidth      = $clog2(FifoDepth);

  localparam logic [15:0] EthTypeVlan  = 16'h8100;
  localparam logic [15:0] EthTypeQinQ  = 16'h88A8;
  localparam logic [15:0] EthTypeIpv4  = 16'h0800;
  localparam logic [15:0] EthTypeIpv6  = 16'h86DD;
  localparam logic [4:0]  EthHdrLen    = 5'd14;
  localparam logic [4:0]  VlanTagLen   = 5'd4;
  localparam logic [7:0]  Ipv4ProtoOff = 8'd9;
  localparam logic [7:0]  Ipv6NextOff  = 8'd6;
  localparam logic [7:0]  Ipv4HdrLen   = 8'd20;
  localparam logic [7:0]  Ipv6HdrLen   = 8'd40;
  localparam logic [6:0]  PosMax       = 7'd127;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic {
    KIND_FRAME = 1'b0,
    KIND_READ  = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    PH_ETH   = 3'd0,
    PH_VLAN1 = 3'd1,
    PH_VLAN2 = 3'd2,
    PH_IPV4  = 3'd3,
    PH_IPV6  = 3'd4,
    PH_OTHER = 3'd5
  } phase_e;

  typedef struct packed {
    kind_e               kind;
    logic                counted;
    logic [IdxWidth-1:0] protocol;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/ethernet_ip_protocol_histogram_unit.sv
// Ethernet ip protocol histogram: takes one frame byte or one counter read per
// cycle. The header parser classifies each frame and hands one command per
// frame end or read to a four-entry queue; the counter pipeline does a
// two-stage read-modify-write on a 256-entry ram with a bypass of the latest
// write, so every class, repeated or not, sustains one transaction per cycle.
// A result passes the queue, the counter stage and the output register after
// the transaction that causes it is accepted, is held longer only while the
// output is held off, and waits there; the input stalls only once the queue
// has filled behind a held-off output. Counters are zero after reset through
// one valid flop per entry; no clearing pass is needed.
// depends on ehist_pkg, ehist_parser, ehist_fifo, ehist_counter
`default_nettype none

module ethernet_ip_protocol_histogram_unit import ehist_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // data_byte[7:0], counter_index[15:8]
  input  wire logic        s_axis_tuser,   // op
  input  wire logic        s_axis_tlast,   // last_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata,   // counted[0], protocol[8:1], count[40:9], zero
  output logic             m_axis_tuser    // kind
);

  logic                     in_fire;
  logic                     push;
  cmd_t                     push_cmd;
  logic                     full;
  logic                     q_valid;
  logic                     q_pop;
  cmd_t                     q_cmd;
  cmd_t                     out_cmd;
  logic [OutCountWidth-1:0] out_count;

  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  ehist_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .op_i           (s_axis_tuser),
    .data_byte_i    (s_axis_tdata[7:0]),
    .last_byte_i    (s_axis_tlast),
    .counter_index_i(s_axis_tdata[15:8]),
    .push_o         (push),
    .cmd_o          (push_cmd)
  );

  ehist_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_cmd)
  );

  ehist_counter u_counter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_pop_o    (q_pop),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_cmd_o  (out_cmd),
    .out_count_o(out_count)
  );

  assign m_axis_tuser = out_cmd.kind;
  assign m_axis_tdata = {7'b0, out_count, out_cmd.protocol, out_cmd.counted};

endmodule

`default_nettype wire

>>> design/ehist_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module ehist_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> design/ehist_parser.sv
// front end: walks frame headers byte by byte and issues counter commands
// depends on ehist_pkg
`default_nettype none

module ehist_parser import ehist_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_fire_i,
  input  wire logic                op_i,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                last_byte_i,
  input  wire logic [IdxWidth-1:0] counter_index_i,
  output logic                     push_o,
  output cmd_t                     cmd_o
);

  logic [6:0]  pos_q, pos_d;
  logic [15:0] et_q, et_d;
  logic [4:0]  off_q, off_d;
  phase_e      ph_q, ph_d;
  logic [7:0]  fp_q, fp_d;

  always_comb begin
    logic [7:0]  p_ext;
    logic [7:0]  off_ext;
    logic [7:0]  len;
    logic [15:0] et_full;
    logic        take;
    logic        in_hdr;
    p_ext   = {1'b0, pos_q};
    off_ext = {3'b000, off_q};
    et_full = {et_q[15:8], et_q[7:0] | data_byte_i};
    take    = in_fire_i && (op_i == OP_FRAME);
    pos_d   = pos_q;
    et_d    = et_q;
    off_d   = off_q;
    ph_d    = ph_q;
    fp_d    = fp_q;
    in_hdr  = 1'b0;

    unique case (ph_q)
      PH_ETH, PH_VLAN1, PH_VLAN2: begin
        if (p_ext + 8'd2 == off_ext) begin
          et_d = {data_byte_i, 8'h00};
        end else if (p_ext + 8'd1 == off_ext) begin
          et_d = et_full;
          if ((et_full == EthTypeVlan || et_full == EthTypeQinQ) && ph_q != PH_VLAN2) begin
            off_d = off_q + VlanTagLen;
            ph_d  = (ph_q == PH_ETH) ? PH_VLAN1 : PH_VLAN2;
          end else if (et_full == EthTypeIpv4) begin
            ph_d = PH_IPV4;
          end else if (et_full == EthTypeIpv6) begin
            ph_d = PH_IPV6;
          end else begin
            ph_d = PH_OTHER;
          end
        end
      end
      PH_IPV4: begin
        if (p_ext == off_ext + Ipv4ProtoOff) begin
          fp_d = data_byte_i;
        end
      end
      PH_IPV6: begin
        if (p_ext == off_ext + Ipv6NextOff) begin
          fp_d = data_byte_i;
        end
      end
      default: begin
      end
    endcase
    if (pos_q != PosMax) begin
      pos_d = pos_q + 7'd1;
    end

    len    = {1'b0, pos_d};
    in_hdr = (ph_d == PH_ETH || ph_d == PH_VLAN1 || ph_d == PH_VLAN2);

    cmd_o.kind     = KIND_FRAME;
    cmd_o.counted  = !in_hdr;
    cmd_o.protocol = '0;
    if (ph_d == PH_IPV4 && len >= {3'b000, off_d} + Ipv4HdrLen) begin
      cmd_o.protocol = IdxWidth'(fp_d);
    end else if (ph_d == PH_IPV6 && len >= {3'b000, off_d} + Ipv6HdrLen) begin
      cmd_o.protocol = IdxWidth'(fp_d);
    end
    if (op_i == OP_READ) begin
      cmd_o.kind     = KIND_READ;
      cmd_o.counted  = 1'b0;
      cmd_o.protocol = counter_index_i;
    end
    push_o = in_fire_i && (op_i == OP_READ || last_byte_i);

    // end of frame restarts the header walk
    if (take && last_byte_i) begin
      pos_d = '0;
      et_d  = '0;
      off_d = EthHdrLen;
      ph_d  = PH_ETH;
      fp_d  = '0;
    end else if (!take) begin
      pos_d = pos_q;
      et_d  = et_q;
      off_d = off_q;
      ph_d  = ph_q;
      fp_d  = fp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      et_q  <= '0;
      off_q <= EthHdrLen;
      ph_q  <= PH_ETH;
      fp_q  <= '0;
    end else begin
      pos_q <= pos_d;
      et_q  <= et_d;
      off_q <= off_d;
      ph_q  <= ph_d;
      fp_q  <= fp_d;
    end
  end

endmodule

`default_nettype wire

>>> design/ehist_fifo.sv
// short command queue between header parser and counter pipeline
// depends on ehist_pkg
`default_nettype none

module ehist_fifo import ehist_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t                slot_q [FifoDepth];
  logic [PtrWidth-1:0] wr_q, wr_d;
  logic [PtrWidth-1:0] rd_q, rd_d;
  logic [PtrWidth:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrWidth+1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + PtrWidth'(1) : wr_q;
    rd_d  = pop_i ? rd_q + PtrWidth'(1) : rd_q;
    cnt_d = cnt_q + (PtrWidth+1)'(push_i) - (PtrWidth+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> design/ehist_counter.sv
// back end: counter read-modify-write pipeline and result register
// depends on ehist_pkg, ehist_ram and the assertion macro header
`default_nettype none
`include "ethernet_ip_protocol_histogram_unit_defines.svh"

module ehist_counter import ehist_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     q_valid_i,
  input  wire cmd_t                     q_cmd_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output cmd_t                          out_cmd_o,
  output logic      [OutCountWidth-1:0] out_count_o
);

  logic                     b_valid_q;
  cmd_t                     b_cmd_q;
  logic                     b_fire;
  logic                     b_write;
  logic [CounterDepth-1:0]  valid_q;
  logic                     fwd_valid_q;
  logic [IdxWidth-1:0]      fwd_addr_q;
  logic [CountWidth-1:0]    fwd_val_q;
  logic [CountWidth-1:0]    rdata;
  logic [CountWidth-1:0]    cur_val;
  logic [CountWidth-1:0]    new_val;
  logic                     out_valid_q;
  cmd_t                     out_cmd_q;
  logic [OutCountWidth-1:0] out_count_q;

  assign b_fire  = b_valid_q && (!out_valid_q || out_ready_i);
  assign q_pop_o = q_valid_i && (!b_valid_q || b_fire);
  assign b_write = b_fire && b_cmd_q.kind == KIND_FRAME && b_cmd_q.counted;

  ehist_ram #(
    .Width(CountWidth),
    .Depth(CounterDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (b_write),
    .waddr_i(b_cmd_q.protocol),
    .wdata_i(new_val),
    .re_i   (q_pop_o),
    .raddr_i(q_cmd_i.protocol),
    .rdata_o(rdata)
  );

  // latest write bypasses the ram, never-written counters read as zero
  always_comb begin
    if (fwd_valid_q && fwd_addr_q == b_cmd_q.protocol) begin
      cur_val = fwd_val_q;
    end else if (valid_q[b_cmd_q.protocol]) begin
      cur_val = rdata;
    end else begin
      cur_val = '0;
    end
    new_val = cur_val + CountWidth'(1);
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_cmd_q <= b_cmd_q;
      if (b_cmd_q.kind == KIND_READ) begin
        out_count_q <= OutCountWidth'(cur_val);
      end else if (b_cmd_q.counted) begin
        out_count_q <= OutCountWidth'(new_val);
      end else begin
        out_count_q <= '0;
      end
    end
    if (q_pop_o) begin
      b_cmd_q <= q_cmd_i;
    end
    if (b_write) begin
      fwd_addr_q <= b_cmd_q.protocol;
      fwd_val_q  <= new_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      fwd_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      if (q_pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (b_write) begin
        fwd_valid_q                <= 1'b1;
        valid_q[b_cmd_q.protocol] <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_cmd_o   = out_cmd_q;
  assign out_count_o = out_count_q;

  `EHIST_ASSERT_NEXT(a_write_marks_valid, clk_i, rst_ni, b_write, valid_q[$past(b_cmd_q.protocol)])
  `EHIST_ASSERT_NEXT(a_pop_fills_stage, clk_i, rst_ni, q_pop_o, b_valid_q)
  `EHIST_ASSERT_IMPL(a_read_not_counted, clk_i, rst_ni, out_valid_q && out_cmd_q.kind == KIND_READ, !out_cmd_q.counted)

endmodule

`default_nettype wire
